[sv/rfnb_pkg.sv]
`timescale 1ns / 1ps
package rfnb_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int ENTRY_W = 2 * PIX_W;

    localparam int FW_W       = 10;
    localparam int FH_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 10'd428;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 11'd521;

    localparam int MIN_DIM = 2;

    // neighbour counts: interior, edge, corner
    localparam logic [2:0] CNT_INTERIOR = 3'd4;
    localparam logic [2:0] CNT_EDGE     = 3'd3;
    localparam logic [2:0] CNT_CORNER   = 3'd2;

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048
    localparam int SUM_W      = CHAN_W + 2;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = SUM_W + 10;
    localparam logic [9:0] DIV3_MUL = 10'd683;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr_sel;

endpackage

[sv/rfnb_lane.sv]
`timescale 1ns / 1ps
module rfnb_lane (
    input  logic [rfnb_pkg::CHAN_W-1:0] i_up,
    input  logic [rfnb_pkg::CHAN_W-1:0] i_down,
    input  logic [rfnb_pkg::CHAN_W-1:0] i_left,
    input  logic [rfnb_pkg::CHAN_W-1:0] i_right,
    input  rfnb_pkg::t_nbr_sel          i_sel,
    output logic [rfnb_pkg::CHAN_W-1:0] o_mean
);
    import rfnb_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [2:0]        cnt;
    logic [PROD_W-1:0] prod;

    always_comb begin
        sum = (i_sel.up    ? SUM_W'(i_up)    : '0)
            + (i_sel.down  ? SUM_W'(i_down)  : '0)
            + (i_sel.left  ? SUM_W'(i_left)  : '0)
            + (i_sel.right ? SUM_W'(i_right) : '0);
        cnt = 3'(i_sel.up) + 3'(i_sel.down) + 3'(i_sel.left) + 3'(i_sel.right);
        prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
        unique case (cnt)
            CNT_INTERIOR: o_mean = sum[SUM_W-1:2];
            CNT_EDGE:     o_mean = CHAN_W'(prod >> DIV3_SHIFT);
            CNT_CORNER:   o_mean = sum[SUM_W-2:1];
            default:      o_mean = '0;
        endcase
    end

endmodule

[sv/rfnb_line_store.sv]
`timescale 1ns / 1ps
module rfnb_line_store #(
    parameter int DEPTH = rfnb_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(rfnb_pkg::DEF_MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr_a,
    input  logic [AW-1:0]                i_rd_addr_b,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [rfnb_pkg::ENTRY_W-1:0] i_wr_data,
    output logic [rfnb_pkg::ENTRY_W-1:0] o_rd_data_a,
    output logic [rfnb_pkg::PIX_W-1:0]   o_rd_data_b
);
    import rfnb_pkg::*;

    // entry: {older row pixel, newer row pixel}
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_a;
    logic [PIX_W-1:0]   r_rd_b;
    logic               r_byp_a;
    logic               r_byp_b;
    logic [ENTRY_W-1:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // a write landing on the same edge as the read is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a     <= r_mem[i_rd_addr_a];
            r_rd_b     <= r_mem[i_rd_addr_b][PIX_W-1:0];
            r_byp_a    <= i_wr_en && (i_wr_addr == i_rd_addr_a);
            r_byp_b    <= i_wr_en && (i_wr_addr == i_rd_addr_b);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data_a = r_byp_a ? r_byp_data : r_rd_a;
    assign o_rd_data_b = r_byp_b ? r_byp_data[PIX_W-1:0] : r_rd_b;

endmodule

[sv/rgb_four_neighbour_blur.sv]
`timescale 1ns / 1ps
// Four-neighbour average blur over an RGB frame streamed in raster order.
// Input words carry one pixel (red, green, blue) and a flush bit; output
// words carry the blurred pixel and frame_last on the frame's final pixel.
// Both channels use valid/stall: a word moves on a clock edge with valid
// high and stall low.
// The blurred pixel for row r-1, column c leaves in answer to the input
// word for row r, column c; row 0 produces nothing, and one trailing row of
// frame_width words, flush or not, drains the last row. Geometry comes from the
// frame_width and frame_height registers, written while the block is idle.
// Taken words are registered in stage 1, results in the output register.
// Throughput: one word per clock unless the receiver stalls, set by the line
// store, which serves each pixel's two reads and one write in a single cycle.
// Reset clears the row and column counters and restores the default
// geometry (428 x 521); the line stores are not cleared, and the first two
// rows of a frame refill them before they are read.
// When the receiver stalls, the output word holds and one more word may
// still be taken into the pipeline; after that o_stall rises.
module rgb_four_neighbour_blur #(
    parameter int MAX_WIDTH  = rfnb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rfnb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rfnb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfnb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_red_in,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_green_in,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_blue_in,
    input  logic                            i_flush,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rfnb_pkg::CHAN_W-1:0]     o_red_out,
    output logic [rfnb_pkg::CHAN_W-1:0]     o_green_out,
    output logic [rfnb_pkg::CHAN_W-1:0]     o_blue_out,
    output logic                            o_frame_last
);
    import rfnb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int HCW = (RW + 1 > FH_W) ? RW + 1 : FH_W;

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;

    logic            r_s1_valid;
    logic [CW-1:0]   r_s1_col;
    logic            r_s1_has_out;
    logic            r_s1_last;
    t_nbr_sel        r_s1_sel;
    logic [PIX_W-1:0] r_s1_px;
    logic [PIX_W-1:0] r_left;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;

    logic [WCW-1:0] w_lim, c_inc;
    logic [HCW-1:0] h_lim, r_inc;
    logic           restart, accept, s1_leave;
    logic [CW-1:0]  cur_c, addr_b;
    logic [RW-1:0]  cur_r;
    logic           is_bottom, is_right;
    t_nbr_sel       sel;
    logic [PIX_W-1:0] px;

    logic [ENTRY_W-1:0] rd_a;
    logic [PIX_W-1:0]   rd_b;
    logic [PIX_W-1:0]   centre, up_px;
    logic [PIX_W-1:0]   mean_px;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
            endcase
        end
    end

    // position of the incoming word
    always_comb begin
        w_lim = WCW'(r_frame_width);
        if (w_lim < WCW'(MIN_DIM)) begin
            w_lim = WCW'(MIN_DIM);
        end else if (w_lim > WCW'(MAX_WIDTH)) begin
            w_lim = WCW'(MAX_WIDTH);
        end
        h_lim = HCW'(r_frame_height);
        if (h_lim < HCW'(MIN_DIM)) begin
            h_lim = HCW'(MIN_DIM);
        end else if (h_lim > HCW'(MAX_HEIGHT)) begin
            h_lim = HCW'(MAX_HEIGHT);
        end

        // geometry shrank under the counters: start a new frame
        restart = (WCW'(r_col) >= w_lim) || (HCW'(r_row) > h_lim);
        cur_c   = restart ? '0 : r_col;
        cur_r   = restart ? '0 : r_row;

        c_inc = WCW'(cur_c) + WCW'(1);
        r_inc = HCW'(cur_r) + HCW'(1);
        if (c_inc >= w_lim) begin
            n_col = '0;
            n_row = (r_inc > h_lim) ? '0 : r_inc[RW-1:0];
        end else begin
            n_col = c_inc[CW-1:0];
            n_row = cur_r;
        end

        addr_b = (cur_c == CW'(MAX_WIDTH - 1)) ? '0 : cur_c + CW'(1);

        is_bottom = (HCW'(cur_r) == h_lim);
        is_right  = (WCW'(cur_c) == w_lim - WCW'(1));
        sel.up    = (cur_r != RW'(1));
        sel.down  = !is_bottom;
        sel.left  = (cur_c != '0);
        sel.right = !is_right;

        // trailing row and flush words enter as zero
        px = (i_flush || is_bottom) ? '0 : {i_red_in, i_green_in, i_blue_in};
    end

    assign s1_leave = r_s1_valid && (!r_s1_has_out || !r_out_valid || !i_stall);
    assign o_stall  = r_s1_valid && !s1_leave;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col     <= cur_c;
            r_s1_has_out <= (cur_r != '0);
            r_s1_last    <= is_bottom && is_right;
            r_s1_sel     <= sel;
            r_s1_px      <= px;
        end
        if (s1_leave) begin
            r_left <= centre;
        end
    end

    rfnb_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr_a (cur_c),
        .i_rd_addr_b (addr_b),
        .i_wr_en     (s1_leave),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   ({centre, r_s1_px}),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign up_px  = rd_a[ENTRY_W-1:PIX_W];
    assign centre = rd_a[PIX_W-1:0];

    // one lane per color channel
    for (genvar k = 0; k < 3; k++) begin : g_lane
        rfnb_lane u_lane (
            .i_up    (up_px  [PIX_W-1-CHAN_W*k -: CHAN_W]),
            .i_down  (r_s1_px[PIX_W-1-CHAN_W*k -: CHAN_W]),
            .i_left  (r_left [PIX_W-1-CHAN_W*k -: CHAN_W]),
            .i_right (rd_b   [PIX_W-1-CHAN_W*k -: CHAN_W]),
            .i_sel   (r_s1_sel),
            .o_mean  (mean_px[PIX_W-1-CHAN_W*k -: CHAN_W])
        );
    end

    // merge lanes into the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_leave && r_s1_has_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_leave && r_s1_has_out) begin
            r_out_pix  <= mean_px;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_out    = r_out_pix[PIX_W-1 -: CHAN_W];
    assign o_green_out  = r_out_pix[PIX_W-1-CHAN_W -: CHAN_W];
    assign o_blue_out   = r_out_pix[CHAN_W-1:0];
    assign o_frame_last = r_out_last;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_leave && r_s1_has_out |=> o_valid)
        else $error("result leaving stage 1 not loaded into output");

    a_last_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_leave && r_s1_has_out && r_s1_last |=> o_frame_last)
        else $error("frame_last lost on the way to the output");

    a_counters_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WCW'(r_col) < WCW'(MAX_WIDTH)) && (HCW'(r_row) <= HCW'(MAX_HEIGHT)))
        else $error("position counters beyond the line store or frame");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_leave |=> r_s1_valid && $stable(r_s1_col))
        else $error("stalled stage 1 word replaced");

endmodule

[verif/blur_checker.sv]
`timescale 1ns / 1ps
module blur_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rfnb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfnb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_red,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_green,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_blue,
    input  logic                            i_flush,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_red_out,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_green_out,
    input  logic [rfnb_pkg::CHAN_W-1:0]     i_blue_out,
    input  logic                            i_frame_last,
    output int                              o_pending,
    output int                              o_mismatches,
    output int                              o_checked
);
    import rfnb_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_blurred_word;

    // upper_line: the row above the one in recent_line
    logic [PIX_W-1:0] upper_line  [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] recent_line [DEF_MAX_WIDTH];
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    int               col_pos;
    int               row_pos;
    t_blurred_word    blurred_due [$];
    int               mismatches = 0;
    int               checked = 0;

    function automatic int clamp_dim(int raw, int top);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > top) return top;
        return raw;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic absorb_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                                input logic [CHAN_W-1:0] blue, input logic filler);
        int               w;
        int               h;
        int               c;
        int               r;
        int               n;
        int               sum [3];
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] nbr [4];
        t_blurred_word    word;
        w = clamp_dim(int'(width_reg), DEF_MAX_WIDTH);
        h = clamp_dim(int'(height_reg), DEF_MAX_HEIGHT);
        // geometry shrank under the counters: restart the frame
        if (col_pos >= w || row_pos > h) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        px = (!filler && r < h) ? {red, green, blue} : '0;
        // word at row r emits the blurred pixel of row r-1
        if (r > 0) begin
            n = 0;
            if (r != 1) begin
                nbr[n] = upper_line[c];
                n++;
            end
            if (r != h) begin
                nbr[n] = px;
                n++;
            end
            if (c != 0) begin
                nbr[n] = upper_line[c-1];
                n++;
            end
            if (c != w - 1) begin
                nbr[n] = recent_line[c+1];
                n++;
            end
            sum = '{0, 0, 0};
            for (int k = 0; k < n; k++)
                for (int s = 0; s < 3; s++)
                    sum[s] += nbr[k][PIX_W-1-CHAN_W*s -: CHAN_W];
            word.red   = CHAN_W'(sum[0] / n);
            word.green = CHAN_W'(sum[1] / n);
            word.blue  = CHAN_W'(sum[2] / n);
            word.last  = (r == h) && (c == w - 1);
            blurred_due.push_back(word);
        end
        upper_line[c]  = recent_line[c];
        recent_line[c] = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r > h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_word();
        t_blurred_word want;
        if (blurred_due.size() == 0) begin
            $error("blurred word with none due: red %0d green %0d blue %0d last %0d",
                   i_red_out, i_green_out, i_blue_out, i_frame_last);
            mismatches++;
        end else begin
            want = blurred_due.pop_front();
            compare_field("red_out", want.red, i_red_out);
            compare_field("green_out", want.green, i_green_out);
            compare_field("blue_out", want.blue, i_blue_out);
            compare_field("frame_last", want.last, i_frame_last);
            checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            col_pos    = 0;
            row_pos    = 0;
            blurred_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) width_reg = i_cfg_data[FW_W-1:0];
                else if (i_cfg_index == CFG_FRAME_HEIGHT) height_reg = i_cfg_data[FH_W-1:0];
            end
            if (i_in_valid && !i_in_stall) absorb_pixel(i_red, i_green, i_blue, i_flush);
            if (i_out_valid && !i_out_stall) check_word();
        end
        o_pending    <= blurred_due.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import rfnb_pkg::*;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } t_stall_mode;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pix_valid;
    logic                  dut_stall;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic                  flush;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAN_W-1:0]     red_out;
    logic [CHAN_W-1:0]     green_out;
    logic [CHAN_W-1:0]     blue_out;
    logic                  frame_last;

    int pending;
    int mismatches;
    int checked;

    int frame_w;
    int frame_h;
    int burst_left = 0;
    bit steady = 1'b1;
    int words_sent = 0;
    int frames_sent = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_tick = 0;

    rgb_four_neighbour_blur u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (pix_valid),
        .o_stall      (dut_stall),
        .i_red_in     (red),
        .i_green_in   (green),
        .i_blue_in    (blue),
        .i_flush      (flush),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_red_out    (red_out),
        .o_green_out  (green_out),
        .o_blue_out   (blue_out),
        .o_frame_last (frame_last)
    );

    blur_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (pix_valid),
        .i_in_stall   (dut_stall),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_flush      (flush),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_red_out    (red_out),
        .i_green_out  (green_out),
        .i_blue_out   (blue_out),
        .i_frame_last (frame_last),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: switch between randomly chosen stall patterns
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 160);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    function automatic int effective_dim(int raw, int top);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > top) return top;
        return raw;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // drop valid and wait until every blurred word has come back
    task automatic settle();
        pix_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_raw,
                                input logic [CFG_DATA_W-1:0] h_raw);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w_raw;
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge clk);
        cfg_we  <= 1'b0;
        frame_w = effective_dim(int'(w_raw[FW_W-1:0]), DEF_MAX_WIDTH);
        frame_h = effective_dim(int'(h_raw[FH_W-1:0]), DEF_MAX_HEIGHT);
    endtask

    task automatic pace();
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 30);
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
    endtask

    task automatic push_word(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic fl);
        pace();
        pix_valid <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        flush     <= fl;
        do @(posedge clk); while (dut_stall);
        words_sent++;
    endtask

    // real rows rarely carry a flush; the trailing row mostly does
    task automatic send_frame();
        logic filler;
        steady = ($urandom_range(0, 2) == 0);
        for (int r = 0; r <= frame_h; r++) begin
            for (int c = 0; c < frame_w; c++) begin
                if (r < frame_h) filler = ($urandom_range(0, 24) == 0);
                else filler = ($urandom_range(0, 5) != 0);
                push_word(rand_chan(), rand_chan(), rand_chan(), filler);
            end
        end
        frames_sent++;
    endtask

    initial begin
        logic [CHAN_W-1:0]     hi;
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;
        int                    random_start;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data  = '0;
        pix_valid = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        flush     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // 3 x 3 checkerboard of extremes; flush on the center pixel, and
        // one unmarked word in the trailing row
        set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(3));
        steady = 1'b1;
        for (int r = 0; r <= 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                hi = ((r + c) % 2 == 0) ? '1 : '0;
                push_word(hi, ~hi, (c == 1) ? '1 : '0,
                          (r == 1 && c == 1) || (r == 3 && c != 1));
            end
        end
        frames_sent++;

        // abandon a 4 x 4 frame in row 1, then shrink the width below the
        // column count so the next word restarts the frame
        set_geometry(CFG_DATA_W'(4), CFG_DATA_W'(4));
        repeat (6) push_word(rand_chan(), rand_chan(), rand_chan(), 1'b0);
        set_geometry(CFG_DATA_W'(2), CFG_DATA_W'(3));
        send_frame();

        random_start = words_sent;
        while (words_sent - random_start < 1000) begin
            if (words_sent == random_start || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 7))
                    0: begin
                        w_raw = CFG_DATA_W'($urandom_range(0, 1));
                        h_raw = CFG_DATA_W'($urandom_range(0, 2));
                    end
                    1: begin
                        // upper data bit lies outside the width register
                        w_raw = CFG_DATA_W'(11'h400 | $urandom_range(2, 9));
                        h_raw = CFG_DATA_W'($urandom_range(2, 6));
                    end
                    2: begin
                        w_raw = CFG_DATA_W'($urandom_range(10, 48));
                        h_raw = CFG_DATA_W'(2);
                    end
                    default: begin
                        w_raw = CFG_DATA_W'($urandom_range(2, 9));
                        h_raw = CFG_DATA_W'($urandom_range(2, 7));
                    end
                endcase
                set_geometry(w_raw, h_raw);
            end
            send_frame();
        end

        settle();
        $display("blur run: %0d pixel words over %0d frames, widths 2 to 48, heights 2 to 7",
                 words_sent, frames_sent);
        $display("blur run: %0d blurred words compared, %0d mismatches", checked, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
